// File: hw/rtl/line_table_append_replace_defines.svh
// ----------------------------------------------------------------------------
// Line table assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINE_TABLE_APPEND_REPLACE_DEFINES_SVH
`define LINE_TABLE_APPEND_REPLACE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define LTAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define LTAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTAR_ASSERT(lbl, prop, msg)
`define LTAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/ltar_pkg.sv
// ----------------------------------------------------------------------------
// Line table package
// Word types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ltar_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_W      = 12;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int OCC_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W        = 4 * COORD_W;

  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REPLACED = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_OOB      = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] reject_length;
    logic [COORD_W-1:0] end_limit;
    logic [ADDR_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  slot;
    logic [COORD_W-1:0] out_start_x;
    logic [COORD_W-1:0] out_start_y;
    logic [COORD_W-1:0] out_end_x;
    logic [COORD_W-1:0] out_end_y;
    logic [OCC_W-1:0]   fill_count;
  } result_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_OCC,
    SLOT_IDX,
    SLOT_SCAN
  } slot_sel_t;

  typedef struct packed {
    logic       load;
    logic       wr_en;
    logic       wr_scan;
    logic       inc_occ;
    logic       rd_item;
    logic       scan_clr;
    logic       scan_inc;
    logic       finish;
    logic [1:0] fin_status;
    slot_sel_t  slot_sel;
    logic       show_data;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       full;
    logic       idx_ok;
    logic       match;
    logic       scan_last;
  } dp_status_t;

endpackage

// File: hw/rtl/ltar_ram.sv
// ----------------------------------------------------------------------------
// Line table RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ltar_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/ltar_datapath.sv
// ----------------------------------------------------------------------------
// Line table datapath
// Item register, segment store, fill count, scan pointer and result register.
// ----------------------------------------------------------------------------
module ltar_datapath
  import ltar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  ctl_cmd_t   cmd,
  output dp_status_t stat,
  output logic       done,
  output result_t    result
);

  `include "line_table_append_replace_defines.svh"

  item_t              item_q;
  logic [OCC_W-1:0]   occupied;
  logic [ADDR_W-1:0]  scan_idx;
  logic [ADDR_W-1:0]  scan_next;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SEG_W-1:0]   wr_data;
  logic [SEG_W-1:0]   rd_data;
  logic [COORD_W-1:0] rd_sy;
  logic [COORD_W-1:0] rd_ey;
  logic [COORD_W:0]   diff;
  logic               full;

  assign full      = (occupied == OCC_W'(MAX_SEGMENTS));
  assign scan_next = cmd.scan_clr ? '0 : scan_idx + 1'b1;
  assign rd_addr   = cmd.rd_item ? item_q.read_index : scan_next;
  assign wr_addr   = cmd.wr_scan ? scan_idx : occupied[ADDR_W-1:0];
  assign wr_data   = {item_q.start_x, item_q.start_y, item_q.end_x, item_q.end_y};

  ltar_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // signed length end_y - start_y; negative always passes the length test
  assign rd_ey = rd_data[COORD_W-1:0];
  assign rd_sy = rd_data[3*COORD_W-1:2*COORD_W];
  assign diff  = {1'b0, rd_ey} - {1'b0, rd_sy};

  always_comb begin
    stat.opcode    = item_q.opcode;
    stat.full      = full;
    stat.idx_ok    = ({1'b0, item_q.read_index} < occupied);
    stat.match     = (rd_ey <= item_q.end_limit) &&
                     (diff[COORD_W] || (diff[COORD_W-1:0] <= item_q.reject_length));
    stat.scan_last = (scan_idx == ADDR_W'(MAX_SEGMENTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.inc_occ) begin
        occupied <= occupied + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.finish) begin
      result.status     <= cmd.fin_status;
      result.fill_count <= cmd.inc_occ ? occupied + 1'b1 : occupied;
      case (cmd.slot_sel)
        SLOT_OCC:  result.slot <= occupied[ADDR_W-1:0];
        SLOT_IDX:  result.slot <= item_q.read_index;
        SLOT_SCAN: result.slot <= scan_idx;
        default:   result.slot <= '0;
      endcase
      if (cmd.show_data) begin
        {result.out_start_x, result.out_start_y,
         result.out_end_x, result.out_end_y} <= rd_data;
      end else begin
        {result.out_start_x, result.out_start_y,
         result.out_end_x, result.out_end_y} <= '0;
      end
    end
  end

  `LTAR_ASSERT(a_occ_bound, occupied <= OCC_W'(MAX_SEGMENTS), "fill count overflow")
  `LTAR_ASSERT(a_append_room, (cmd.wr_en && !cmd.wr_scan) |-> !full, "append into full table")
  `LTAR_ASSERT(a_replace_full, (cmd.wr_en && cmd.wr_scan) |-> (full && !cmd.inc_occ), "replace while not full")

endmodule

// File: hw/rtl/ltar_ctrl.sv
// ----------------------------------------------------------------------------
// Line table controller
// Sequences append, read and the replacement scan over the datapath.
// ----------------------------------------------------------------------------
module ltar_ctrl
  import ltar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t stat,
  output ctl_cmd_t   cmd
);

  `include "line_table_append_replace_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.opcode)
          OP_APPEND, OP_REPLACE: begin
            if (!stat.full) begin
              cmd.wr_en      = 1'b1;
              cmd.inc_occ    = 1'b1;
              cmd.finish     = 1'b1;
              cmd.fin_status = STAT_OK;
              cmd.slot_sel   = SLOT_OCC;
              state_next     = ST_IDLE;
            end else if (stat.opcode == OP_REPLACE) begin
              // first read of the scan goes out now
              cmd.scan_clr = 1'b1;
              state_next   = ST_SCAN;
            end else begin
              cmd.finish     = 1'b1;
              cmd.fin_status = STAT_FULL;
              state_next     = ST_IDLE;
            end
          end
          OP_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_item = 1'b1;
              state_next  = ST_READ;
            end else begin
              cmd.finish     = 1'b1;
              cmd.fin_status = STAT_OOB;
              state_next     = ST_IDLE;
            end
          end
          default: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = STAT_OOB;
            state_next     = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = STAT_OK;
        cmd.slot_sel   = SLOT_IDX;
        cmd.show_data  = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        // read data is the entry at the scan pointer
        cmd.scan_inc = 1'b1;
        if (stat.match) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_scan    = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_REPLACED;
          cmd.slot_sel   = SLOT_SCAN;
          state_next     = ST_IDLE;
        end else if (stat.scan_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_FULL;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  `LTAR_ASSERT(a_finish_frees, cmd.finish |=> !busy, "busy after finish")
  `LTAR_ASSERT(a_scan_full, (state == ST_SCAN) |-> stat.full, "scan with free slots")
  `LTAR_ASSERT(a_busy_state, busy == (state != ST_IDLE), "busy out of step with state")

endmodule

// File: hw/rtl/line_table_append_replace.sv
// Appends (a replace with room too), failed appends, failed reads and unknown
// opcodes finish from the exec state, and a read from the read state. A full
// replace scans up from slot 0 to the first match, else reports full.
// The scan reads one stored segment per cycle from the single RAM read port.
// busy drops in the cycle done shows, so a new word can start there.
// Sync reset clears the fill count and control; table contents are not cleared.
// ----------------------------------------------------------------------------
// Line table append/replace
// Fixed-capacity segment table with append, append-or-replace and read.
// ----------------------------------------------------------------------------
module line_table_append_replace
  import ltar_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  ctl_cmd_t   cmd;
  dp_status_t stat;

  ltar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ltar_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule
